FILE: rtl/gf256_arithmetic_unit_core_macros.svh
// ----------------------------------------------------------------------------
// GF(2^8) arithmetic unit assertion macros
// Shared assertion shorthands; every macro samples on clk, and all but the reset one are disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef GF256_ARITHMETIC_UNIT_CORE_MACROS_SVH
`define GF256_ARITHMETIC_UNIT_CORE_MACROS_SVH

// Check the consequent on the cycle after the antecedent, outside reset
`define GF256_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// Check the consequent in the same cycle as the antecedent, outside reset
`define GF256_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check the consequent on the next cycle, reset included
`define GF256_ASSERT_RST(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/gf256_pkg.sv
// ----------------------------------------------------------------------------
// GF(2^8) arithmetic unit package
// Field constants, opcodes, table fill bus and modulo-255 folding helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package gf256_pkg;

  localparam int GF_ELEM_W = 8;
  localparam int GF_EXP_W  = 16;

  // Field polynomial x^8+x^4+x^3+x^2+1 and multiplicative group order
  localparam logic [8:0]           GF_POLY  = 9'h11D;
  localparam logic [GF_ELEM_W-1:0] GF_ORDER = 8'd255;
  localparam logic [GF_ELEM_W-1:0] GF_ONE   = 8'd1;
  localparam logic [GF_ELEM_W-1:0] GF_ZERO  = 8'd0;

  // Operation codes
  typedef enum logic [2:0] {
    FN_ADD = 3'd0,
    FN_MUL = 3'd1,
    FN_POW = 3'd2,
    FN_INV = 3'd3,
    FN_DIV = 3'd4,
    FN_LOG = 3'd5
  } gf_func_t;

  // Result source at the output stage
  typedef enum logic [1:0] {
    SEL_EXP  = 2'd0,
    SEL_ZERO = 2'd1,
    SEL_ONE  = 2'd2,
    SEL_PASS = 2'd3
  } gf_sel_t;

  // Table fill sequencer states
  typedef enum logic {
    INIT_FILL = 1'b0,
    INIT_DONE = 1'b1
  } gf_init_state_t;

  // Table write bus from the fill sequencer
  typedef struct packed {
    logic                 busy;
    logic                 we;
    logic [GF_ELEM_W-1:0] exp_addr;
    logic [GF_ELEM_W-1:0] exp_data;
    logic [GF_ELEM_W-1:0] log_addr;
    logic [GF_ELEM_W-1:0] log_data;
  } gf_tbl_wr_t;

  // Multiply a field element by the generator 2
  function automatic logic [GF_ELEM_W-1:0] gf_mul2(input logic [GF_ELEM_W-1:0] a);
    logic [GF_ELEM_W-1:0] sh;
    sh = {a[GF_ELEM_W-2:0], 1'b0};
    return a[GF_ELEM_W-1] ? (sh ^ GF_POLY[GF_ELEM_W-1:0]) : sh;
  endfunction

  // Fold a 9-bit sum to 0..255, congruent modulo 255 (sum stays below 511)
  function automatic logic [GF_ELEM_W-1:0] gf_fold9(input logic [GF_ELEM_W:0] s);
    return s[GF_ELEM_W-1:0] + {{(GF_ELEM_W-1){1'b0}}, s[GF_ELEM_W]};
  endfunction

  // Reduce a 16-bit value to 0..255, congruent modulo 255
  function automatic logic [GF_ELEM_W-1:0] gf_fold16(input logic [GF_EXP_W-1:0] v);
    logic [GF_ELEM_W:0] s;
    s = {1'b0, v[GF_EXP_W-1:GF_ELEM_W]} + {1'b0, v[GF_ELEM_W-1:0]};
    return gf_fold9(s);
  endfunction

endpackage

`default_nettype wire

FILE: rtl/gf256_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and two read ports with registered, enable-held read data.
// ----------------------------------------------------------------------------
`default_nettype none

module gf256_ram #(
  parameter  int WIDTH = 8,
  parameter  int DEPTH = 256,
  localparam int AW    = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re_a,
  input  wire logic [AW-1:0]    raddr_a,
  output logic      [WIDTH-1:0] rdata_a,
  input  wire logic             re_b,
  input  wire logic [AW-1:0]    raddr_b,
  output logic      [WIDTH-1:0] rdata_b
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_a_r;
  logic [WIDTH-1:0] rdata_b_r;

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // Read ports, hold data while disabled
  always_ff @(posedge clk) begin
    if (re_a) begin
      rdata_a_r <= mem_r[raddr_a];
    end
    if (re_b) begin
      rdata_b_r <= mem_r[raddr_b];
    end
  end

  assign rdata_a = rdata_a_r;
  assign rdata_b = rdata_b_r;

endmodule

`default_nettype wire

FILE: rtl/gf256_tbl_init.sv
// ----------------------------------------------------------------------------
// GF(2^8) table fill sequencer
// Sweeps the exponent and logarithm tables once after reset, one entry a cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module gf256_tbl_init (
  input  wire logic            clk,
  input  wire logic            rst_n,
  output gf256_pkg::gf_tbl_wr_t wr
);

  import gf256_pkg::*;

  gf_init_state_t       state_r, state_nxt;
  logic [GF_ELEM_W-1:0] idx_r, idx_nxt;
  logic [GF_ELEM_W-1:0] pow_r, pow_nxt;

  // State and sweep registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= INIT_FILL;
      idx_r   <= GF_ZERO;
      pow_r   <= GF_ONE;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
      pow_r   <= pow_nxt;
    end
  end

  // Walk powers of the generator; the last step writes log of zero
  always_comb begin
    state_nxt   = state_r;
    idx_nxt     = idx_r;
    pow_nxt     = pow_r;
    wr.busy     = 1'b0;
    wr.we       = 1'b0;
    wr.exp_addr = idx_r;
    wr.exp_data = pow_r;
    wr.log_addr = (idx_r == GF_ORDER) ? GF_ZERO : pow_r;
    wr.log_data = idx_r;
    unique case (state_r)
      INIT_FILL: begin
        wr.busy = 1'b1;
        wr.we   = 1'b1;
        idx_nxt = idx_r + 8'd1;
        pow_nxt = gf_mul2(pow_r);
        if (idx_r == GF_ORDER) begin
          state_nxt = INIT_DONE;
        end
      end
      INIT_DONE: begin
        wr.busy = 1'b0;
      end
      default: begin
        state_nxt = INIT_FILL;
      end
    endcase
  end

endmodule

`default_nettype wire

FILE: rtl/gf256_arithmetic_unit_core.sv
// ----------------------------------------------------------------------------
// GF(2^8) arithmetic unit
// Add, multiply, power, inverse, divide and log over polynomial 0x11D,
// built on log and antilog tables held in RAM.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake          | payload
//  ---------+-----------+--------------------+-------------------------------
//  in_      | in        | in_valid/in_stall  | func, operand_a/b, exponent
//  out_     | out       | out_valid/out_stall| result
//
//  One beat per cycle while out_stall is low; out_valid rises as a beat leaves stage 3.
//  The pipeline is log RAM read, log add/multiply, antilog RAM read, output.
//  After reset the tables fill; in_stall stays high meanwhile.
//  A stalled output holds each stage only as far back as the next bubble.
// ----------------------------------------------------------------------------
`default_nettype none

module gf256_arithmetic_unit_core (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [2:0]  in_func,
  input  wire logic [7:0]  in_operand_a,
  input  wire logic [7:0]  in_operand_b,
  input  wire logic [15:0] in_exponent,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [7:0]       out_result
);

  import gf256_pkg::*;

  gf_tbl_wr_t tbl_wr;

  // Stage load enables
  logic ld1, ld2, ld3, ld4;
  logic acc;

  // Stage 1: operands beside the log RAM read
  logic                 v1_r;
  gf_func_t             func1_r;
  logic                 a_zero1_r, b_zero1_r;
  logic [GF_ELEM_W-1:0] xor1_r;
  logic [GF_ELEM_W-1:0] e1_r;
  logic [GF_ELEM_W-1:0] log_a, log_b;
  logic [GF_ELEM_W-1:0] e_fold;

  // Stage 2: exponent arithmetic
  logic                 v2_r;
  logic                 pow2_r;
  logic [GF_EXP_W-1:0]  prod2_r;
  logic [GF_ELEM_W:0]   sum2_r, sum_nxt;
  gf_sel_t              sel2_r, sel_nxt;
  logic [GF_ELEM_W-1:0] pass2_r;
  logic [GF_ELEM_W-1:0] exp_raddr;

  // Stage 3: antilog RAM read
  logic                 v3_r;
  gf_sel_t              sel3_r;
  logic [GF_ELEM_W-1:0] pass3_r;
  logic [GF_ELEM_W-1:0] exp_rdata;

  // Output register
  logic                 out_valid_r;
  logic [GF_ELEM_W-1:0] out_result_r, result_nxt;

  // Table fill after reset
  gf256_tbl_init u_init (
    .clk   (clk),
    .rst_n (rst_n),
    .wr    (tbl_wr)
  );

  // Log table, read at both operands
  gf256_ram #(.WIDTH(GF_ELEM_W), .DEPTH(256)) u_log_ram (
    .clk     (clk),
    .we      (tbl_wr.we),
    .waddr   (tbl_wr.log_addr),
    .wdata   (tbl_wr.log_data),
    .re_a    (ld1),
    .raddr_a (in_operand_a),
    .rdata_a (log_a),
    .re_b    (ld1),
    .raddr_b (in_operand_b),
    .rdata_b (log_b)
  );

  // Antilog table, entry 255 equals entry 0
  gf256_ram #(.WIDTH(GF_ELEM_W), .DEPTH(256)) u_exp_ram (
    .clk     (clk),
    .we      (tbl_wr.we),
    .waddr   (tbl_wr.exp_addr),
    .wdata   (tbl_wr.exp_data),
    .re_a    (ld3),
    .raddr_a (exp_raddr),
    .rdata_a (exp_rdata),
    .re_b    (1'b0),
    .raddr_b (GF_ZERO),
    .rdata_b ()
  );

  // Advance each stage when it is empty or the next one moves
  assign ld4      = !out_valid_r || !out_stall;
  assign ld3      = !v3_r || ld4;
  assign ld2      = !v2_r || ld3;
  assign ld1      = !v1_r || ld2;
  assign in_stall = tbl_wr.busy || !ld1;
  assign acc      = in_valid && !in_stall;

  // Reduce the exponent modulo 255 up front
  assign e_fold = gf_fold16(in_exponent);

  // Valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (ld1) v1_r <= acc;
      if (ld2) v2_r <= v1_r;
      if (ld3) v3_r <= v2_r;
      if (ld4) out_valid_r <= v3_r;
    end
  end

  // Stage 1 payload
  always_ff @(posedge clk) begin
    if (ld1) begin
      func1_r   <= gf_func_t'(in_func);
      a_zero1_r <= (in_operand_a == GF_ZERO);
      b_zero1_r <= (in_operand_b == GF_ZERO);
      xor1_r    <= in_operand_a ^ in_operand_b;
      e1_r      <= e_fold;
    end
  end

  // Log sums and result source per operation
  always_comb begin
    sum_nxt = {1'b0, log_a};
    sel_nxt = SEL_ZERO;
    unique case (func1_r)
      FN_ADD: begin
        sel_nxt = SEL_PASS;
      end
      FN_MUL: begin
        sum_nxt = {1'b0, log_a} + {1'b0, log_b};
        sel_nxt = (a_zero1_r || b_zero1_r) ? SEL_ZERO : SEL_EXP;
      end
      FN_POW: begin
        if (e1_r == GF_ZERO || e1_r == GF_ORDER) begin
          sel_nxt = SEL_ONE;
        end else begin
          sel_nxt = a_zero1_r ? SEL_ZERO : SEL_EXP;
        end
      end
      FN_INV: begin
        sum_nxt = {1'b0, GF_ORDER - log_a};
        sel_nxt = a_zero1_r ? SEL_ZERO : SEL_EXP;
      end
      FN_DIV: begin
        sum_nxt = {1'b0, log_a} + {1'b0, GF_ORDER - log_b};
        sel_nxt = (a_zero1_r || b_zero1_r) ? SEL_ZERO : SEL_EXP;
      end
      FN_LOG: begin
        sel_nxt = SEL_PASS;
      end
      default: begin
        sel_nxt = SEL_ZERO;
      end
    endcase
  end

  // Stage 2 payload, power multiplies log by exponent
  always_ff @(posedge clk) begin
    if (ld2) begin
      pow2_r  <= (func1_r == FN_POW);
      prod2_r <= {8'd0, log_a} * {8'd0, e1_r};
      sum2_r  <= sum_nxt;
      sel2_r  <= sel_nxt;
      pass2_r <= (func1_r == FN_LOG) ? log_a : xor1_r;
    end
  end

  // Fold to an antilog address
  assign exp_raddr = pow2_r ? gf_fold16(prod2_r) : gf_fold9(sum2_r);

  // Stage 3 payload beside the antilog read
  always_ff @(posedge clk) begin
    if (ld3) begin
      sel3_r  <= sel2_r;
      pass3_r <= pass2_r;
    end
  end

  // Pick the result
  always_comb begin
    case (sel3_r)
      SEL_EXP:  result_nxt = exp_rdata;
      SEL_ZERO: result_nxt = GF_ZERO;
      SEL_ONE:  result_nxt = GF_ONE;
      SEL_PASS: result_nxt = pass3_r;
      default:  result_nxt = GF_ZERO;
    endcase
  end

  // Output register
  always_ff @(posedge clk) begin
    if (ld4) begin
      out_result_r <= result_nxt;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_result = out_result_r;

endmodule

`default_nettype wire

FILE: rtl/gf256_checker.sv
// ----------------------------------------------------------------------------
// GF(2^8) arithmetic unit port checker
// Watches the top-level ports for reset, table fill and beat hold behavior.
// ----------------------------------------------------------------------------
`default_nettype none

`include "gf256_arithmetic_unit_core_macros.svh"

module gf256_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_stall,
  input wire logic [2:0]  in_func,
  input wire logic [7:0]  in_operand_a,
  input wire logic [7:0]  in_operand_b,
  input wire logic [15:0] in_exponent,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [7:0]  out_result
);

  logic in_beat;

  assign in_beat = in_valid && !in_stall;

  // Reset empties the pipeline and starts the table fill
  `GF256_ASSERT_RST(a_reset_clears, !rst_n, in_stall && !out_valid,
    "reset did not clear output and block input")

  // Tables are still filling right after reset release
  `GF256_ASSERT_NOW(a_fill_stall, $rose(rst_n), in_stall && !in_beat,
    "input taken before table fill")

  // A stalled input beat holds
  `GF256_ASSERT_NEXT(a_in_hold, in_valid && in_stall,
    in_valid && $stable({in_func, in_operand_a, in_operand_b, in_exponent}),
    "stalled input beat changed")

  // A stalled result beat holds
  `GF256_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_result),
    "stalled result beat changed")

endmodule

bind gf256_arithmetic_unit_core gf256_checker u_gf256_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_valid),
  .in_stall     (in_stall),
  .in_func      (in_func),
  .in_operand_a (in_operand_a),
  .in_operand_b (in_operand_b),
  .in_exponent  (in_exponent),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .out_result   (out_result)
);

`default_nettype wire

FILE: tb/gf256_arithmetic_unit_core_checker.sv
// ----------------------------------------------------------------------------
// GF(2^8) arithmetic unit result checker
// Watches both channels of the unit. For each accepted input beat it predicts
// the field result and queues it. Each accepted output beat is compared with
// the oldest queued prediction.
// ----------------------------------------------------------------------------
module gf256_result_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [2:0]  in_func,
  input  logic [7:0]  in_operand_a,
  input  logic [7:0]  in_operand_b,
  input  logic [15:0] in_exponent,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [7:0]  out_result,
  output int          mismatch_count,
  output int          results_pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import gf256_pkg::*;

  logic [7:0] expected_results[$];

  // Carry-less multiply with reduction by the field polynomial
  function automatic logic [7:0] gf_product(input logic [7:0] x, input logic [7:0] y);
    logic [7:0] acc;
    logic [7:0] sh;
    acc = GF_ZERO;
    sh  = x;
    for (int i = 0; i < 8; i++) begin
      if (y[i]) acc ^= sh;
      sh = sh[7] ? ({sh[6:0], 1'b0} ^ GF_POLY[7:0]) : {sh[6:0], 1'b0};
    end
    return acc;
  endfunction

  // Square and multiply; exponent already reduced below the group order
  function automatic logic [7:0] gf_raise(input logic [7:0] x, input int unsigned e);
    logic [7:0] acc;
    logic [7:0] sq;
    int unsigned k;
    acc = GF_ONE;
    sq  = x;
    k   = e;
    while (k != 0) begin
      if (k[0]) acc = gf_product(acc, sq);
      sq = gf_product(sq, sq);
      k  = k >> 1;
    end
    return acc;
  endfunction

  // Zero has no inverse and maps to zero
  function automatic logic [7:0] gf_reciprocal(input logic [7:0] x);
    if (x == GF_ZERO) return GF_ZERO;
    return gf_raise(x, 254);
  endfunction

  // Walk powers of the generator; log of zero is the group order
  function automatic logic [7:0] gf_discrete_log(input logic [7:0] x);
    logic [7:0] p;
    p = GF_ONE;
    if (x == GF_ZERO) return GF_ORDER;
    for (int i = 0; i < 255; i++) begin
      if (p == x) return 8'(i);
      p = gf_product(p, 8'd2);
    end
    return GF_ORDER;
  endfunction

  function automatic logic [7:0] predict_result(input logic [2:0] func, input logic [7:0] a,
                                                input logic [7:0] b, input logic [15:0] e);
    case (func)
      FN_ADD:  return a ^ b;
      FN_MUL:  return gf_product(a, b);
      FN_POW:  return gf_raise(a, int'(e) % 255);
      FN_INV:  return gf_reciprocal(a);
      FN_DIV:  return gf_product(a, gf_reciprocal(b));
      FN_LOG:  return gf_discrete_log(a);
      default: return GF_ZERO;
    endcase
  endfunction

  initial begin
    mismatch_count  = 0;
    results_pending = 0;
  end

  // Compare output beats first, then queue the prediction for an input beat
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          $error("result beat with nothing expected: actual %0h", out_result);
          mismatch_count++;
        end else if (out_result !== expected_results[0]) begin
          $error("result mismatch: expected %0h, actual %0h", expected_results[0], out_result);
          mismatch_count++;
          void'(expected_results.pop_front());
        end else begin
          void'(expected_results.pop_front());
        end
      end
      if (in_valid && !in_stall)
        expected_results.push_back(predict_result(in_func, in_operand_a, in_operand_b,
                                                  in_exponent));
      results_pending = expected_results.size();
    end
  end

endmodule

FILE: tb/testbench.sv
// ----------------------------------------------------------------------------
// GF(2^8) arithmetic unit regression
// Drives directed corner cases and random operations into the unit with
// random gaps and output stalls, including a long output hold-off, and
// reports the verdict from the checker's mismatch and pending counts.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import gf256_pkg::*;

  localparam int RUN_ITEMS    = 1300;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 12;
  localparam int DRAIN_LIMIT  = 5000;

  // Opcodes the unit leaves unused; their result is zero
  localparam logic [2:0] FN_SPARE6 = 3'd6;
  localparam logic [2:0] FN_SPARE7 = 3'd7;

  logic        clk          = 1'b0;
  logic        rst_n        = 1'b0;
  logic        in_valid     = 1'b0;
  logic        in_stall;
  logic [2:0]  in_func      = 3'd0;
  logic [7:0]  in_operand_a = 8'd0;
  logic [7:0]  in_operand_b = 8'd0;
  logic [15:0] in_exponent  = 16'd0;
  logic        out_valid;
  logic        out_stall    = 1'b0;
  logic [7:0]  out_result;

  int mismatch_count;
  int results_pending;
  int cycle_count  = 0;
  int gap_pct      = 0;
  int stall_pct    = 0;
  bit hold_request = 1'b0;

  gf256_arithmetic_unit_core uut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_func      (in_func),
    .in_operand_a (in_operand_a),
    .in_operand_b (in_operand_b),
    .in_exponent  (in_exponent),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_result   (out_result)
  );

  gf256_result_checker u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_func         (in_func),
    .in_operand_a    (in_operand_a),
    .in_operand_b    (in_operand_b),
    .in_exponent     (in_exponent),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_result      (out_result),
    .mismatch_count  (mismatch_count),
    .results_pending (results_pending)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("gf256_arithmetic_unit_core regression: fail");
      $finish;
    end
  end

  // Output side: random stalls, plus one long hold-off counted here
  initial begin
    int held;
    held = 0;
    forever begin
      @(negedge clk);
      if (hold_request && held < HOLD_CYCLES) begin
        held++;
        out_stall <= 1'b1;
      end else begin
        out_stall <= (stall_pct > 0 && $urandom_range(0, 99) < stall_pct);
      end
    end
  end

  // Offer one beat, with random gaps ahead of it, and hold it until accepted
  task automatic offer_beat(input logic [2:0] f, input logic [7:0] a, input logic [7:0] b,
                            input logic [15:0] e);
    while (gap_pct > 0 && $urandom_range(0, 99) < gap_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid     <= 1'b1;
    in_func      <= f;
    in_operand_a <= a;
    in_operand_b <= b;
    in_exponent  <= e;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  // Bias toward zero, one and all-ones
  function automatic logic [7:0] pick_element();
    case ($urandom_range(0, 9))
      0:       return 8'h00;
      1:       return 8'h01;
      2:       return 8'hFF;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic logic [15:0] pick_exponent();
    case ($urandom_range(0, 7))
      0:       return 16'($urandom_range(0, 257) * 255);
      1:       return 16'($urandom_range(0, 300));
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  initial begin
    logic [2:0] f;
    int waited;
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;

    // Directed corners
    offer_beat(FN_ADD, 8'h00, 8'hFF, 16'h0000);
    offer_beat(FN_ADD, 8'hFF, 8'hFF, 16'hFFFF);
    offer_beat(FN_ADD, 8'hA5, 8'h5A, 16'h0000);
    offer_beat(FN_MUL, 8'hFF, 8'hFF, 16'h0000);
    offer_beat(FN_MUL, 8'h00, 8'h37, 16'h0000);
    offer_beat(FN_MUL, 8'h80, 8'h02, 16'h0000);
    offer_beat(FN_MUL, 8'h01, 8'hC3, 16'h0000);
    offer_beat(FN_POW, 8'h00, 8'h00, 16'd0);
    offer_beat(FN_POW, 8'h00, 8'h00, 16'd255);
    offer_beat(FN_POW, 8'h00, 8'h00, 16'd1);
    offer_beat(FN_POW, 8'h02, 8'h00, 16'hFFFF);
    offer_beat(FN_POW, 8'h03, 8'h00, 16'd254);
    offer_beat(FN_POW, 8'hFF, 8'hFF, 16'hFFFE);
    offer_beat(FN_INV, 8'h00, 8'h00, 16'h0000);
    offer_beat(FN_INV, 8'h01, 8'h00, 16'h0000);
    offer_beat(FN_INV, 8'hFF, 8'h00, 16'h0000);
    offer_beat(FN_DIV, 8'h53, 8'h00, 16'h0000);
    offer_beat(FN_DIV, 8'h00, 8'h05, 16'h0000);
    offer_beat(FN_DIV, 8'hFF, 8'hFF, 16'h0000);
    offer_beat(FN_LOG, 8'h00, 8'h00, 16'h0000);
    offer_beat(FN_LOG, 8'h01, 8'h00, 16'h0000);
    offer_beat(FN_LOG, 8'hFF, 8'h00, 16'h0000);
    offer_beat(FN_LOG, 8'h8E, 8'h00, 16'h0000);
    offer_beat(FN_SPARE6, 8'hFF, 8'hFF, 16'hFFFF);
    offer_beat(FN_SPARE7, 8'h3C, 8'hC3, 16'h1234);

    // Random operations across idle phases
    gap_pct   = 15;
    stall_pct = 15;
    for (int n = 0; n < RUN_ITEMS; n++) begin
      if (n == 300) hold_request = 1'b1;
      if (n == 700) begin
        gap_pct   = 0;
        stall_pct = 0;
      end
      if (n == 1000) begin
        gap_pct   = 15;
        stall_pct = 15;
      end
      if ($urandom_range(0, 99) < 6)
        f = $urandom_range(0, 1) ? FN_SPARE6 : FN_SPARE7;
      else
        f = 3'($urandom_range(0, 5));
      offer_beat(f, pick_element(), pick_element(), pick_exponent());
    end
    in_valid <= 1'b0;

    // Drain outstanding results, then let the pipeline settle
    waited = 0;
    while (results_pending != 0 && waited < DRAIN_LIMIT) begin
      @(negedge clk);
      waited++;
    end
    repeat (DRAIN_CYCLES) @(negedge clk);

    if (mismatch_count == 0 && results_pending == 0) begin
      $display("gf256_arithmetic_unit_core regression: pass");
    end else begin
      $display("gf256_arithmetic_unit_core regression: fail");
    end
    $finish;
  end

endmodule
